[hdl/ybchs_pkg.sv]
package ybchs_pkg;

  // input word: one luma sample or one U,V pair
  typedef struct packed {
    logic       req_type;
    logic [7:0] sample_first;
    logic [7:0] sample_second;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [7:0] result_first;
    logic [7:0] result_second;
  } out_word_t;

  // item kinds
  localparam logic KIND_LUMA   = 1'b0;
  localparam logic KIND_CHROMA = 1'b1;

  // register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_CONTRAST   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BRIGHTNESS = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_HUE_COS    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_HUE_SIN    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SATURATION = 3'd4;
  localparam int unsigned CfgDataW = 14;

  // register reset values
  localparam logic [12:0]        CONTRAST_RST   = 13'd512;
  localparam logic signed [9:0]  BRIGHTNESS_RST = 10'sd16;
  localparam logic signed [13:0] HUE_COS_RST    = 14'sd4096;
  localparam logic signed [13:0] HUE_SIN_RST    = 14'sd0;
  localparam logic [12:0]        SATURATION_RST = 13'd512;

  // centering offsets and clamp limits
  localparam logic signed [8:0]  LUMA_BLACK  = 9'sd16;
  localparam logic signed [8:0]  CHROMA_MID  = 9'sd128;
  localparam logic signed [16:0] LUMA_LO     = 17'sd15;
  localparam logic signed [16:0] LUMA_HI     = 17'sd235;
  localparam logic signed [16:0] CHROMA_LO   = 17'sd16;
  localparam logic signed [16:0] CHROMA_HI   = 17'sd240;

  // clamp a signed value into an 8-bit window
  function automatic logic [7:0] clamp_u8(input logic signed [16:0] x,
                                          input logic signed [16:0] lo,
                                          input logic signed [16:0] hi);
    logic signed [16:0] r;
    begin
      r = x;
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      return r[7:0];
    end
  endfunction

endpackage

[hdl/ybchs_chroma.sv]
module ybchs_chroma import ybchs_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [7:0]         u_in,
  input  logic [7:0]         v_in,
  input  logic signed [13:0] hue_cos,
  input  logic signed [13:0] hue_sin,
  input  logic [12:0]        sat_gain,
  output logic [7:0]         u_out,
  output logic [7:0]         v_out
);

  // centered chroma
  logic signed [8:0] u_c;
  logic signed [8:0] v_c;
  assign u_c = $signed({1'b0, u_in}) - CHROMA_MID;
  assign v_c = $signed({1'b0, v_in}) - CHROMA_MID;

  // stage 1: four rotation products
  logic signed [21:0] uc_nxt, vs_nxt, vc_nxt, us_nxt;
  logic signed [21:0] uc_r, vs_r, vc_r, us_r;
  assign uc_nxt = u_c * hue_cos;
  assign vs_nxt = v_c * hue_sin;
  assign vc_nxt = v_c * hue_cos;
  assign us_nxt = u_c * hue_sin;

  always_ff @(posedge clk) begin
    if (en) begin
      uc_r <= uc_nxt;
      vs_r <= vs_nxt;
      vc_r <= vc_nxt;
      us_r <= us_nxt;
    end
  end

  // stage 2: rotate sums, floor shift by 12
  logic signed [22:0] ur_sum;
  logic signed [22:0] vr_sum;
  logic signed [10:0] ur_nxt, vr_nxt;
  logic signed [10:0] ur_r, vr_r;
  assign ur_sum = {uc_r[21], uc_r} + {vs_r[21], vs_r};
  assign vr_sum = {vc_r[21], vc_r} - {us_r[21], us_r};
  assign ur_nxt = ur_sum[22:12];
  assign vr_nxt = vr_sum[22:12];

  always_ff @(posedge clk) begin
    if (en) begin
      ur_r <= ur_nxt;
      vr_r <= vr_nxt;
    end
  end

  // stage 3: saturation scaling
  logic signed [13:0] sat_s;
  logic signed [24:0] usat_nxt, vsat_nxt;
  logic signed [24:0] usat_r, vsat_r;
  assign sat_s    = $signed({1'b0, sat_gain});
  assign usat_nxt = ur_r * sat_s;
  assign vsat_nxt = vr_r * sat_s;

  always_ff @(posedge clk) begin
    if (en) begin
      usat_r <= usat_nxt;
      vsat_r <= vsat_nxt;
    end
  end

  // floor shift by 9, recenter, clamp
  logic signed [16:0] uo_sum;
  logic signed [16:0] vo_sum;
  assign uo_sum = {usat_r[24], usat_r[24:9]} + 17'(CHROMA_MID);
  assign vo_sum = {vsat_r[24], vsat_r[24:9]} + 17'(CHROMA_MID);
  assign u_out  = clamp_u8(uo_sum, CHROMA_LO, CHROMA_HI);
  assign v_out  = clamp_u8(vo_sum, CHROMA_LO, CHROMA_HI);

endmodule

[hdl/yuv_brightness_contrast_hue_saturation_core.sv]
// an accepted input word reaches its result word through the stage registers and then the output word register
// throughput: one word per cycle when not stalled; the four-stage multiply pipeline advances as one
// a stall at the output holds every stage in place, so nothing is lost or repeated
// reset (rst_n low, synchronous) clears all valid bits and loads the default
// gains: unity contrast and saturation, brightness 16, hue angle zero
module yuv_brightness_contrast_hue_saturation_core import ybchs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_word_t            in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output out_word_t           out_word,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  // configuration registers
  logic [12:0]        contrast_r;
  logic signed [9:0]  brightness_r;
  logic signed [13:0] hue_cos_r;
  logic signed [13:0] hue_sin_r;
  logic [12:0]        saturation_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      contrast_r   <= CONTRAST_RST;
      brightness_r <= BRIGHTNESS_RST;
      hue_cos_r    <= HUE_COS_RST;
      hue_sin_r    <= HUE_SIN_RST;
      saturation_r <= SATURATION_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_CONTRAST:   contrast_r   <= cfg_wdata[12:0];
        REG_BRIGHTNESS: brightness_r <= $signed(cfg_wdata[9:0]);
        REG_HUE_COS:    hue_cos_r    <= $signed(cfg_wdata[13:0]);
        REG_HUE_SIN:    hue_sin_r    <= $signed(cfg_wdata[13:0]);
        REG_SATURATION: saturation_r <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  // pipeline advance: the whole pipe moves unless the output word is held
  logic out_valid_r;
  logic en;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // valid and kind travel with the data
  logic v1_r, v2_r, v3_r;
  logic k1_r, k2_r, k3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k1_r <= in_word.req_type;
      k2_r <= k1_r;
      k3_r <= k2_r;
    end
  end

  // luma stage 1: contrast product
  logic signed [8:0]  y_c;
  logic signed [13:0] cont_s;
  logic signed [21:0] yprod_nxt;
  logic signed [21:0] yprod_r;
  assign y_c       = $signed({1'b0, in_word.sample_first}) - LUMA_BLACK;
  assign cont_s    = $signed({1'b0, contrast_r});
  assign yprod_nxt = y_c * cont_s;

  // luma stage 2: floor shift by 9, brightness, clamp
  logic signed [16:0] y_sum;
  logic [7:0]         y2_nxt;
  logic [7:0]         y2_r, y3_r;
  assign y_sum  = {{4{yprod_r[21]}}, yprod_r[21:9]} + 17'(brightness_r);
  assign y2_nxt = clamp_u8(y_sum, LUMA_LO, LUMA_HI);

  always_ff @(posedge clk) begin
    if (en) begin
      yprod_r <= yprod_nxt;
      y2_r    <= y2_nxt;
      y3_r    <= y2_r;
    end
  end

  // chroma path, three stages deep like the luma path
  logic [7:0] u_res, v_res;

  ybchs_chroma u_chroma (
    .clk      (clk),
    .en       (en),
    .u_in     (in_word.sample_first),
    .v_in     (in_word.sample_second),
    .hue_cos  (hue_cos_r),
    .hue_sin  (hue_sin_r),
    .sat_gain (saturation_r),
    .u_out    (u_res),
    .v_out    (v_res)
  );

  // output word register
  out_word_t out_word_nxt;
  out_word_t out_word_r;
  logic      out_kind_r;

  always_comb begin
    if (k3_r == KIND_LUMA) begin
      out_word_nxt.result_first  = y3_r;
      out_word_nxt.result_second = 8'd0;
    end else begin
      out_word_nxt.result_first  = u_res;
      out_word_nxt.result_second = v_res;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word_r <= out_word_nxt;
      out_kind_r <= k3_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // luma words carry a zero second result
  a_luma_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_LUMA |-> out_word_r.result_second == 8'd0)
    else $error("luma word with nonzero second result");

  // every first result lies inside the span of the luma and chroma clamp windows
  a_result_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_word_r.result_first >= 8'd15 && out_word_r.result_first <= 8'd240)
    else $error("result outside clamp window");

  // chroma words stay in the chroma window on the second result and above its low limit on the first
  a_chroma_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_CHROMA |->
      out_word_r.result_second >= 8'd16 && out_word_r.result_second <= 8'd240 &&
      out_word_r.result_first >= 8'd16)
    else $error("chroma result outside window");

  // a valid word in the third stage moves into the output register when the pipe advances
  a_valid_flow: assert property (@(posedge clk) disable iff (!rst_n)
    en && v3_r |=> out_valid_r)
    else $error("valid word dropped at the output stage");

  // the input is held back only while a finished word waits
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall)
    else $error("input stalled with no waiting output word");

endmodule

[tb/sv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ybchs_pkg::*;

  localparam int HalfPeriod = 10;
  localparam int PipeDepth  = 4;
  localparam int DrainSlack = PipeDepth + 4;
  localparam int MaxReports = 10;
  localparam int NumPhases  = 12;
  localparam int WordsPerPhase = 125;

  // arithmetic of the adjustment chain
  localparam int LumaShift = 9;
  localparam int RotShift  = 12;
  localparam int GainShift = 9;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_word_t            in_word;
  logic                out_valid;
  logic                out_stall;
  out_word_t           out_word;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  yuv_brightness_contrast_hue_saturation_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // shadow copy of the adjustment registers
  logic [12:0]        contrast_q;
  logic signed [9:0]  bright_q;
  logic signed [13:0] hue_cos_q;
  logic signed [13:0] hue_sin_q;
  logic [12:0]        sat_q;

  in_word_t  pixel_q[$];
  out_word_t adjusted_q[$];
  int        fail_cnt;
  int        gap_cnt;
  int        stall_left;
  bit        src_gaps;
  bit        sink_stalls;

  logic [7:0] corner_vals [0:13] = '{8'd0, 8'd1, 8'd15, 8'd16, 8'd17, 8'd127, 8'd128,
                                     8'd129, 8'd235, 8'd236, 8'd240, 8'd241, 8'd254,
                                     8'd255};

  always #HalfPeriod clk = ~clk;

  // saturate into an 8-bit window
  function automatic logic [7:0] saturate(input int x, input int lo, input int hi);
    int r;
    r = x;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r[7:0];
  endfunction

  // expected output word for one pixel word under the current settings
  function automatic out_word_t adjust_pixel(input in_word_t w);
    out_word_t res;
    int a, b, cont, bright, c, s, sat, u, v, ur, vr;
    a      = int'(w.sample_first);
    b      = int'(w.sample_second);
    cont   = int'(contrast_q);
    bright = int'(bright_q);
    c      = int'(hue_cos_q);
    s      = int'(hue_sin_q);
    sat    = int'(sat_q);
    if (w.req_type == KIND_LUMA) begin
      res.result_first  = saturate((((a - int'(LUMA_BLACK)) * cont) >>> LumaShift) + bright,
                                   int'(LUMA_LO), int'(LUMA_HI));
      res.result_second = '0;
    end else begin
      u  = a - int'(CHROMA_MID);
      v  = b - int'(CHROMA_MID);
      ur = (u * c + v * s) >>> RotShift;
      vr = (v * c - u * s) >>> RotShift;
      res.result_first  = saturate(((ur * sat) >>> GainShift) + int'(CHROMA_MID),
                                   int'(CHROMA_LO), int'(CHROMA_HI));
      res.result_second = saturate(((vr * sat) >>> GainShift) + int'(CHROMA_MID),
                                   int'(CHROMA_LO), int'(CHROMA_HI));
    end
    return res;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_sample();
    if ($urandom_range(0, 4) == 0) return corner_vals[4'($urandom_range(0, 13))];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic in_word_t rand_pixel();
    in_word_t w;
    w.req_type      = 1'($urandom_range(0, 1));
    w.sample_first  = pick_sample();
    w.sample_second = pick_sample();
    return w;
  endfunction

  function automatic in_word_t mk_pixel(input logic kind, input logic [7:0] a,
                                        input logic [7:0] b);
    in_word_t w;
    w.req_type      = kind;
    w.sample_first  = a;
    w.sample_second = b;
    return w;
  endfunction

  // driver: feeds pending words, predicts each accepted one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_cnt  <= 0;
    end else begin
      if (in_valid && !in_stall) adjusted_q.push_back(adjust_pixel(in_word));
      if (!in_valid || !in_stall) begin
        if (gap_cnt > 0) begin
          gap_cnt  <= gap_cnt - 1;
          in_valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          in_word  <= pixel_q.pop_front();
          in_valid <= 1'b1;
          gap_cnt  <= src_gaps ? draw_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each accepted result word, drives random back-pressure
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (adjusted_q.size() == 0) begin
          if (fail_cnt < MaxReports)
            $display("ERROR: unexpected result word %h at %0t", out_word, $time);
          fail_cnt++;
        end else begin
          want = adjusted_q.pop_front();
          if (out_word.result_first !== want.result_first ||
              out_word.result_second !== want.result_second) begin
            if (fail_cnt < MaxReports)
              $display("ERROR: at %0t first exp %0d got %0d, second exp %0d got %0d",
                       $time, want.result_first, out_word.result_first,
                       want.result_second, out_word.result_second);
            fail_cnt++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else begin
        out_stall  <= 1'b0;
        stall_left <= (sink_stalls && $urandom_range(0, 3) == 0) ? draw_gap() : 0;
      end
    end
  end

  // update the shadow registers as the block does
  task automatic shadow_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    case (idx)
      REG_CONTRAST:   contrast_q = val[12:0];
      REG_BRIGHTNESS: bright_q   = val[9:0];
      REG_HUE_COS:    hue_cos_q  = val;
      REG_HUE_SIN:    hue_sin_q  = val;
      REG_SATURATION: sat_q      = val[12:0];
      default: ;
    endcase
  endtask

  // one register write; caller lowers cfg_we after the last one
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    shadow_write(idx, val);
  endtask

  task automatic load_setting(input logic [CfgDataW-1:0] cont, input logic [CfgDataW-1:0] bright,
                              input logic [CfgDataW-1:0] hc, input logic [CfgDataW-1:0] hs,
                              input logic [CfgDataW-1:0] sat);
    write_reg(REG_CONTRAST, cont);
    write_reg(REG_BRIGHTNESS, bright);
    write_reg(REG_HUE_COS, hc);
    write_reg(REG_HUE_SIN, hs);
    write_reg(REG_SATURATION, sat);
  endtask

  // either plausible picture settings or raw values over the full port width
  task automatic random_setting();
    int cont, bright, hc, hs, sat;
    if ($urandom_range(0, 2) != 0) begin
      cont   = $urandom_range(0, 1536);
      bright = $urandom_range(0, 1023);
      hc     = int'($urandom_range(0, 8192)) - 4096;
      hs     = int'($urandom_range(0, 8192)) - 4096;
      sat    = $urandom_range(0, 1536);
    end else begin
      cont   = $urandom_range(0, 2**CfgDataW - 1);
      bright = $urandom_range(0, 2**CfgDataW - 1);
      hc     = $urandom_range(0, 2**CfgDataW - 1);
      hs     = $urandom_range(0, 2**CfgDataW - 1);
      sat    = $urandom_range(0, 2**CfgDataW - 1);
    end
    load_setting(CfgDataW'(cont), CfgDataW'(bright), CfgDataW'(hc), CfgDataW'(hs),
                 CfgDataW'(sat));
  endtask

  // wait until every word has gone through and its result came back
  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_valid || adjusted_q.size() != 0) @(posedge clk);
    repeat (DrainSlack) @(posedge clk);
  endtask

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_word     = '0;
    out_stall   = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_wdata   = '0;
    fail_cnt    = 0;
    gap_cnt     = 0;
    stall_left  = 0;
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    contrast_q  = CONTRAST_RST;
    bright_q    = BRIGHTNESS_RST;
    hue_cos_q   = HUE_COS_RST;
    hue_sin_q   = HUE_SIN_RST;
    sat_q       = SATURATION_RST;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph > 0) begin
        wait_idle();
        case (ph)
          1: begin
            // minimum gains, most negative brightness offset
            load_setting(CfgDataW'(0), CfgDataW'(-512), CfgDataW'(-4096), CfgDataW'(4096),
                         CfgDataW'(0));
            // writes to unused indexes must not disturb anything
            for (int k = REG_SATURATION + 1; k < 2**CfgIdxW; k++)
              write_reg(CfgIdxW'(k), CfgDataW'($urandom_range(0, 2**CfgDataW - 1)));
          end
          2: load_setting(CfgDataW'(8191), CfgDataW'(511), CfgDataW'(8191), CfgDataW'(-8192),
                          CfgDataW'(8191));
          3: load_setting(CfgDataW'(512), CfgDataW'(16), CfgDataW'(-8192), CfgDataW'(8191),
                          CfgDataW'(512));
          4: load_setting(CfgDataW'(CONTRAST_RST), CfgDataW'(BRIGHTNESS_RST),
                          CfgDataW'(HUE_COS_RST), CfgDataW'(HUE_SIN_RST),
                          CfgDataW'(SATURATION_RST));
          default: random_setting();
        endcase
        cfg_we <= 1'b0;
        src_gaps    = (ph == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
        sink_stalls = (ph == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      end else begin
        // directed words under reset settings
        pixel_q.push_back(mk_pixel(KIND_LUMA, 8'd0, 8'd0));
        pixel_q.push_back(mk_pixel(KIND_LUMA, 8'd15, 8'd0));
        pixel_q.push_back(mk_pixel(KIND_LUMA, 8'd16, 8'd255));
        pixel_q.push_back(mk_pixel(KIND_LUMA, 8'd17, 8'd0));
        pixel_q.push_back(mk_pixel(KIND_LUMA, 8'd128, 8'd170));
        pixel_q.push_back(mk_pixel(KIND_LUMA, 8'd235, 8'd0));
        pixel_q.push_back(mk_pixel(KIND_LUMA, 8'd255, 8'd255));
        pixel_q.push_back(mk_pixel(KIND_CHROMA, 8'd128, 8'd128));
        pixel_q.push_back(mk_pixel(KIND_CHROMA, 8'd0, 8'd0));
        pixel_q.push_back(mk_pixel(KIND_CHROMA, 8'd255, 8'd255));
        pixel_q.push_back(mk_pixel(KIND_CHROMA, 8'd0, 8'd255));
        pixel_q.push_back(mk_pixel(KIND_CHROMA, 8'd255, 8'd0));
        pixel_q.push_back(mk_pixel(KIND_CHROMA, 8'd16, 8'd240));
        pixel_q.push_back(mk_pixel(KIND_CHROMA, 8'd240, 8'd16));
      end
      for (int i = 0; i < WordsPerPhase; i++) pixel_q.push_back(rand_pixel());
    end

    wait_idle();
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // overall watchdog
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
